// File: design/isl_pkg.sv
package isl_pkg;

	localparam int DEPTH       = 64;
	localparam int ENTRY_WIDTH = 64;

	localparam int POS_W  = 7;
	localparam int DATA_W = 64;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	typedef enum logic [2:0] {
		REQ_INSERT  = 3'd0,
		REQ_APPEND  = 3'd1,
		REQ_PREPEND = 3'd2,
		REQ_REMOVE  = 3'd3,
		REQ_READ    = 3'd4,
		REQ_CLEAR   = 3'd5
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_ARG   = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_UP,
		CELL_DOWN
	} cell_op_t;

	typedef struct packed {
		cell_op_t               op;
		logic [IDX_W-1:0]       at;
		logic [ENTRY_WIDTH-1:0] value;
	} cell_ctl_t;

endpackage

// File: design/isl_cell.sv
module isl_cell
	import isl_pkg::*;
(
	input  logic                   clk,
	input  logic [IDX_W-1:0]       cell_index,
	input  cell_ctl_t              ctl,
	input  logic [ENTRY_WIDTH-1:0] left_data,
	input  logic [ENTRY_WIDTH-1:0] right_data,
	output logic [ENTRY_WIDTH-1:0] data
);

	logic [ENTRY_WIDTH-1:0] data_q;
	logic [ENTRY_WIDTH-1:0] data_d;

	always_comb begin
		data_d = data_q;
		case (ctl.op)
			CELL_UP: begin
				if (cell_index > ctl.at) begin
					data_d = left_data;
				end else if (cell_index == ctl.at) begin
					data_d = ctl.value;
				end
			end
			CELL_DOWN: begin
				if (cell_index >= ctl.at) begin
					data_d = right_data;
				end
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

// File: design/indexed_shift_list.sv
// An ordered list of up to DEPTH entries kept in a row of cells, one entry per
// cell, where each cell can take its lower or upper neighbor's entry. For
// insert, append, prepend, read, clear and every rejected request, the result
// item is registered at the edge that accepts the request. A remove of N
// entries moves the tail down one place per cycle, so it holds in_stall while
// the tail is still shifting after acceptance; its result is issued at once.
// A new item is accepted whenever no remove is shifting and the output
// register is empty or being taken in the same cycle.
module indexed_shift_list
	import isl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        req_type,
	input  logic [POS_W-1:0]  position,
	input  logic [POS_W-1:0]  run_length,
	input  logic [DATA_W-1:0] entry_value,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [DATA_W-1:0] read_value,
	output logic [POS_W-1:0]  entry_total,
	output logic [1:0]        status
);

	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       count_d;
	logic [CNT_W-1:0]       rem_q;
	logic [IDX_W-1:0]       rem_at_q;
	logic                   out_valid_q;
	logic [ENTRY_WIDTH-1:0] read_value_q;
	status_t                status_q;

	logic                   accept;
	logic                   shifting;
	logic [CMP_W-1:0]       pos_w;
	logic [CMP_W-1:0]       len_w;
	logic [CMP_W-1:0]       cnt_w;
	logic [CMP_W-1:0]       ins_at;
	status_t                st_d;
	logic                   rd_ok;
	logic                   start_remove;
	cell_ctl_t              req_ctl;
	cell_ctl_t              ctl;

	logic [ENTRY_WIDTH-1:0] cell_data [DEPTH];

	assign shifting = (rem_q != '0);
	assign in_stall = shifting || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;

	assign pos_w = CMP_W'(position);
	assign len_w = CMP_W'(run_length);
	assign cnt_w = CMP_W'(count_q);

	always_comb begin
		st_d          = ST_OK;
		rd_ok         = 1'b0;
		start_remove  = 1'b0;
		count_d       = count_q;
		ins_at        = '0;
		req_ctl.op    = CELL_HOLD;
		req_ctl.at    = pos_w[IDX_W-1:0];
		req_ctl.value = entry_value[ENTRY_WIDTH-1:0];
		unique case (req_type)
			REQ_INSERT, REQ_APPEND, REQ_PREPEND: begin
				if (req_type == REQ_INSERT) begin
					ins_at = pos_w;
				end else if (req_type == REQ_APPEND) begin
					ins_at = cnt_w;
				end
				req_ctl.at = ins_at[IDX_W-1:0];
				if (ins_at > cnt_w) begin
					st_d = ST_ARG;
				end else if (cnt_w == CMP_W'(DEPTH)) begin
					st_d = ST_FULL;
				end else begin
					req_ctl.op = CELL_UP;
					count_d    = count_q + CNT_W'(1);
				end
			end
			REQ_REMOVE: begin
				if (pos_w + len_w > cnt_w) begin
					st_d = ST_ARG;
				end else begin
					count_d = CNT_W'(cnt_w - len_w);
					if (len_w != '0) begin
						req_ctl.op   = CELL_DOWN;
						start_remove = 1'b1;
					end
				end
			end
			REQ_READ: begin
				if (pos_w >= cnt_w) begin
					st_d = ST_RANGE;
				end else begin
					rd_ok = 1'b1;
				end
			end
			REQ_CLEAR: begin
				count_d = '0;
			end
			default: st_d = ST_ARG;
		endcase
	end

	always_comb begin
		ctl    = req_ctl;
		if (shifting) begin
			ctl.op = CELL_DOWN;
			ctl.at = rem_at_q;
		end else if (!accept) begin
			ctl.op = CELL_HOLD;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [ENTRY_WIDTH-1:0] left_d;
		logic [ENTRY_WIDTH-1:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_left
			assign left_d = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_right
			assign right_d = cell_data[i+1];
		end
		isl_cell u_cell (
			.clk        (clk),
			.cell_index (IDX_W'(i)),
			.ctl        (ctl),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rem_q       <= '0;
			rem_at_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (shifting) begin
				rem_q <= rem_q - CNT_W'(1);
			end else if (accept && start_remove) begin
				rem_q    <= CNT_W'(len_w - CMP_W'(1));
				rem_at_q <= pos_w[IDX_W-1:0];
			end
			if (accept) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q     <= st_d;
			read_value_q <= rd_ok ? cell_data[pos_w[IDX_W-1:0]] : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_value  = DATA_W'(read_value_q);
	assign entry_total = POS_W'(count_q);
	assign status      = status_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_w <= CMP_W'(DEPTH))
		else $error("entry count above depth");

	a_count_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		shifting |=> $stable(count_q))
		else $error("entry count changed during a remove shift");

	a_result_issued: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted item produced no result");

	a_shift_bound: assert property (@(posedge clk) disable iff (!arst_n)
		shifting |-> (CMP_W'(rem_at_q) <= cnt_w)
			&& (CMP_W'(rem_q) + CMP_W'(rem_at_q) < CMP_W'(DEPTH)))
		else $error("remove shift runs past the end of the list");
`endif

endmodule

// File: dv/tb_indexed_shift_list.sv
module tb_indexed_shift_list;
	import isl_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RAND_ITEMS = 2000;
	localparam int LONG_HOLD = 300;
	localparam logic [2:0] REQ_BAD6 = 3'd6;
	localparam logic [2:0] REQ_BAD7 = 3'd7;
	localparam logic [DATA_W-1:0] ENTRY_MASK = {DATA_W{1'b1}} >> (DATA_W - ENTRY_WIDTH);

	typedef struct packed {
		logic [DATA_W-1:0] rd;
		logic [POS_W-1:0]  total;
		logic [1:0]        st;
	} list_result_t;

	typedef struct packed {
		logic [2:0]        req;
		logic [POS_W-1:0]  pos;
		logic [POS_W-1:0]  len;
		logic [DATA_W-1:0] val;
		bit                typed;
		list_result_t      want;
	} list_req_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [2:0]        req_type;
	logic [POS_W-1:0]  position;
	logic [POS_W-1:0]  run_length;
	logic [DATA_W-1:0] entry_value;
	logic              out_valid;
	logic              out_stall;
	logic [DATA_W-1:0] read_value;
	logic [POS_W-1:0]  entry_total;
	logic [1:0]        status;

	logic [DATA_W-1:0] shadow_mem [DEPTH];
	int                shadow_len;
	list_result_t      pending_results [$];
	list_req_t         directed_tbl [$];
	int                mismatches;
	int                results_seen;
	bit                calm;

	indexed_shift_list uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.position    (position),
		.run_length  (run_length),
		.entry_value (entry_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.read_value  (read_value),
		.entry_total (entry_total),
		.status      (status)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic list_result_t predict_list_op(logic [2:0] req, logic [POS_W-1:0] pos,
			logic [POS_W-1:0] len, logic [DATA_W-1:0] val);
		list_result_t r;
		int at;
		int i;
		r = '0;
		case (req)
			REQ_INSERT, REQ_APPEND, REQ_PREPEND: begin
				if (req == REQ_INSERT)
					at = int'(pos);
				else if (req == REQ_APPEND)
					at = shadow_len;
				else
					at = 0;
				if (at > shadow_len) begin
					r.st = ST_ARG;
				end else if (shadow_len >= DEPTH) begin
					r.st = ST_FULL;
				end else begin
					for (i = shadow_len; i > at; i--)
						shadow_mem[i] = shadow_mem[i - 1];
					shadow_mem[at] = val & ENTRY_MASK;
					shadow_len++;
					r.st = ST_OK;
				end
			end
			REQ_REMOVE: begin
				if (int'(pos) + int'(len) > shadow_len) begin
					r.st = ST_ARG;
				end else begin
					for (i = int'(pos); i + int'(len) < shadow_len; i++)
						shadow_mem[i] = shadow_mem[i + int'(len)];
					shadow_len -= int'(len);
					r.st = ST_OK;
				end
			end
			REQ_READ: begin
				if (int'(pos) >= shadow_len) begin
					r.st = ST_RANGE;
				end else begin
					r.rd = shadow_mem[pos] & ENTRY_MASK;
					r.st = ST_OK;
				end
			end
			REQ_CLEAR: begin
				shadow_len = 0;
				r.st = ST_OK;
			end
			default: begin
				r.st = ST_ARG;
			end
		endcase
		r.total = shadow_len[POS_W-1:0];
		return r;
	endfunction

	function automatic list_req_t plain_row(logic [2:0] req, int pos, int len,
			logic [DATA_W-1:0] val);
		list_req_t s;
		s = '0;
		s.req = req;
		s.pos = pos[POS_W-1:0];
		s.len = len[POS_W-1:0];
		s.val = val;
		return s;
	endfunction

	function automatic list_req_t known_row(logic [2:0] req, int pos, int len,
			logic [DATA_W-1:0] val, logic [DATA_W-1:0] rd, int total, status_t st);
		list_req_t s;
		s = plain_row(req, pos, len, val);
		s.typed = 1'b1;
		s.want.rd = rd;
		s.want.total = total[POS_W-1:0];
		s.want.st = st;
		return s;
	endfunction

	function automatic logic [DATA_W-1:0] rand_value();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic list_req_t pick_item(int mode);
		list_req_t s;
		int room;
		s = '0;
		s.val = rand_value();
		s.pos = POS_W'($urandom_range(0, 127));
		s.len = POS_W'($urandom_range(0, 127));
		case (mode)
			0, 1, 2, 3: begin
				case ($urandom_range(0, 2))
					0: begin
						s.req = REQ_INSERT;
						s.pos = POS_W'($urandom_range(0, shadow_len));
					end
					1: s.req = REQ_APPEND;
					default: s.req = REQ_PREPEND;
				endcase
			end
			4, 5: begin
				s.req = REQ_REMOVE;
				s.pos = POS_W'($urandom_range(0, shadow_len));
				room = shadow_len - int'(s.pos);
				s.len = ($urandom_range(0, 3) == 0) ? POS_W'(room)
					: POS_W'($urandom_range(0, room));
			end
			6, 7: begin
				if (shadow_len > 0 && $urandom_range(0, 3) != 0) begin
					s.req = REQ_READ;
					s.pos = POS_W'($urandom_range(0, shadow_len - 1));
				end else begin
					s.req = REQ_INSERT;
					s.pos = POS_W'($urandom_range(0, shadow_len));
				end
			end
			8: begin
				case ($urandom_range(0, 4))
					0: begin
						s.req = REQ_INSERT;
						s.pos = POS_W'($urandom_range(shadow_len + 1, 127));
					end
					1: begin
						s.req = REQ_REMOVE;
						s.pos = POS_W'($urandom_range(0, shadow_len));
						s.len = POS_W'($urandom_range(shadow_len - int'(s.pos) + 1, 127));
					end
					2: begin
						s.req = REQ_READ;
						s.pos = POS_W'($urandom_range(shadow_len, 127));
					end
					3: s.req = ($urandom_range(0, 3) == 0) ? REQ_CLEAR : REQ_BAD6;
					default: s.req = ($urandom_range(0, 1) == 0) ? REQ_BAD6 : REQ_BAD7;
				endcase
			end
			default: begin
				s.req = 3'($urandom_range(0, 7));
			end
		endcase
		return s;
	endfunction

	task automatic send_item(input list_req_t s);
		list_result_t predicted;
		@(negedge clk);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		req_type <= s.req;
		position <= s.pos;
		run_length <= s.len;
		entry_value <= s.val;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		predicted = predict_list_op(s.req, s.pos, s.len, s.val);
		pending_results.push_back(s.typed ? s.want : predicted);
	endtask

	always @(posedge clk) begin : result_check
		list_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result item with no request outstanding");
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (read_value !== want.rd) begin
					$error("read_value: expected %h, got %h", want.rd, read_value);
					mismatches++;
				end
				if (entry_total !== want.total) begin
					$error("entry_total: expected %0d, got %0d", want.total, entry_total);
					mismatches++;
				end
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					mismatches++;
				end
			end
		end
	end

	// The long hold backs results up into the output register and then the input.
	initial begin : result_sink
		int burst;
		bit held_off;
		held_off = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!held_off && results_seen >= 400) begin
				held_off = 1'b1;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				out_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 12);
				out_stall <= 1'b1;
				repeat (burst) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : stimulus
		int mode;
		int burst_len;
		int sent;
		int k;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_CLEAR;
		position = '0;
		run_length = '0;
		entry_value = '0;
		shadow_len = 0;
		mismatches = 0;
		results_seen = 0;
		calm = 1'b0;

		directed_tbl.push_back(known_row(REQ_READ, 0, 0, '0, '0, 0, ST_RANGE));
		directed_tbl.push_back(known_row(REQ_REMOVE, 0, 0, '0, '0, 0, ST_OK));
		directed_tbl.push_back(known_row(REQ_INSERT, 1, 0, '1, '0, 0, ST_ARG));
		directed_tbl.push_back(known_row(REQ_CLEAR, 0, 0, '0, '0, 0, ST_OK));
		directed_tbl.push_back(known_row(REQ_APPEND, 0, 0, '1, '0, 1, ST_OK));
		directed_tbl.push_back(known_row(REQ_PREPEND, 0, 0, '0, '0, 2, ST_OK));
		directed_tbl.push_back(plain_row(REQ_INSERT, 1, 0, 64'hA5A5_5A5A_F00D_C0DE));
		directed_tbl.push_back(plain_row(REQ_INSERT, 3, 0, 64'h8000_0000_0000_0001));
		directed_tbl.push_back(known_row(REQ_INSERT, 5, 0, '1, '0, 4, ST_ARG));
		directed_tbl.push_back(plain_row(REQ_READ, 0, 0, '0));
		directed_tbl.push_back(plain_row(REQ_READ, 1, 0, '0));
		directed_tbl.push_back(plain_row(REQ_READ, 2, 0, '0));
		directed_tbl.push_back(plain_row(REQ_READ, 3, 0, '0));
		directed_tbl.push_back(known_row(REQ_READ, 4, 0, '0, '0, 4, ST_RANGE));
		directed_tbl.push_back(known_row(REQ_READ, 127, 127, '1, '0, 4, ST_RANGE));
		directed_tbl.push_back(known_row(REQ_REMOVE, 1, 127, '0, '0, 4, ST_ARG));
		directed_tbl.push_back(known_row(REQ_REMOVE, 127, 0, '0, '0, 4, ST_ARG));
		directed_tbl.push_back(known_row(REQ_REMOVE, 4, 0, '0, '0, 4, ST_OK));
		directed_tbl.push_back(known_row(REQ_BAD6, 0, 0, '0, '0, 4, ST_ARG));
		directed_tbl.push_back(known_row(REQ_BAD7, 127, 127, '1, '0, 4, ST_ARG));
		directed_tbl.push_back(plain_row(REQ_REMOVE, 1, 2, '0));
		directed_tbl.push_back(plain_row(REQ_READ, 1, 0, '0));
		directed_tbl.push_back(known_row(REQ_CLEAR, 0, 0, '0, '0, 0, ST_OK));

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_tbl[i])
			send_item(directed_tbl[i]);

		sent = 0;
		while (sent < RAND_ITEMS) begin
			mode = $urandom_range(0, 9);
			burst_len = (mode <= 3) ? $urandom_range(10, 75) : $urandom_range(3, 30);
			for (k = 0; k < burst_len && sent < RAND_ITEMS; k++) begin
				calm = (sent >= RAND_ITEMS * 17 / 20);
				send_item(pick_item(mode));
				sent++;
			end
		end
		@(negedge clk);
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 16) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin : watchdog
		#20_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: filelist.f
design/isl_pkg.sv
design/isl_cell.sv
design/indexed_shift_list.sv
dv/tb_indexed_shift_list.sv
